>>> hw/rtl/tss_pkg.sv
// ----------------------------------------------------------------------------
// tss_pkg: shared types and constants of the timed strike scheduler
// Command, drive and register codes, reset values, stick states, shared ALU request/result.
// ----------------------------------------------------------------------------
package tss_pkg;

  localparam int CLK_W = 32;

  localparam logic [2:0] CMD_TICK  = 3'd0;
  localparam logic [2:0] CMD_REQ   = 3'd1;
  localparam logic [2:0] CMD_SET   = 3'd2;
  localparam logic [2:0] CMD_SCHED = 3'd3;
  localparam logic [2:0] CMD_HIT   = 3'd4;

  localparam logic [1:0] DRIVE_NONE    = 2'd0;
  localparam logic [1:0] DRIVE_STRIKE  = 2'd1;
  localparam logic [1:0] DRIVE_RETRACT = 2'd2;

  localparam logic [1:0] REG_NODE_MASK = 2'd0;
  localparam logic [1:0] REG_COOLDOWN  = 2'd1;
  localparam logic [1:0] REG_SINGLE    = 2'd2;

  localparam logic [7:0]  NODE_MASK_RST = 8'd1;
  localparam logic [15:0] COOLDOWN_RST  = 16'd64;

  typedef enum logic [1:0] {
    STICK_READY     = 2'd0,
    STICK_STRUCK    = 2'd1,
    STICK_RETRACTED = 2'd2
  } stick_t;

  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_t;

  typedef struct packed {
    alu_op_t            op;
    logic [CLK_W-1:0]   a;
    logic [CLK_W-1:0]   b;
  } alu_req_t;

  typedef struct packed {
    logic [CLK_W-1:0]   sum;
    logic               carry;  // add: overflow; sub: no borrow (a >= b)
    logic               zero;
  } alu_res_t;

endpackage

>>> hw/rtl/tss_ram.sv
// ----------------------------------------------------------------------------
// tss_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module tss_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> hw/rtl/tss_alu.sv
// ----------------------------------------------------------------------------
// tss_alu: shared 32-bit add/subtract unit
// Serves clock increments, adjustments, release times and all time compares.
// ----------------------------------------------------------------------------
module tss_alu import tss_pkg::*; (
  input  alu_req_t req,
  output alu_res_t res
);

  logic [CLK_W-1:0] b_x;
  logic [CLK_W:0]   full;

  assign b_x  = (req.op == ALU_SUB) ? ~req.b : req.b;
  assign full = {1'b0, req.a} + {1'b0, b_x} + (CLK_W + 1)'(req.op == ALU_SUB);

  assign res.sum   = full[CLK_W-1:0];
  assign res.carry = full[CLK_W];
  assign res.zero  = (full[CLK_W-1:0] == '0);

endmodule

>>> hw/rtl/timed_strike_scheduler.sv
// ----------------------------------------------------------------------------
// timed_strike_scheduler: virtual tick clock, strike queue and stick control
// Each word steps from S_MSG through the skip loop of a forward clock jump, the head
//   read and compare (passed over with an empty queue), the release check, a retract
//   if due and S_FIRE to S_OUT; in_tready rises as the result word is loaded.
// Words are taken one at a time as the sequencer steps one shared adder/comparator.
// Reset (rst_n low, synchronous): clock, queue pointers, pending flag and
//   release time cleared, stick ready, registers at defaults; queue RAM kept.
// ----------------------------------------------------------------------------
module timed_strike_scheduler import tss_pkg::*; #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // target_mask[7:0], value[39:8]
  input  logic [2:0]  in_tuser,   // cmd[2:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // reply_clock[31:0], drive[33:32], refused[34]
  output logic [0:0]  out_tuser,  // reply_valid[0]
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);
  localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

  typedef enum logic [9:0] {
    S_IDLE     = 10'b00_0000_0001,
    S_MSG      = 10'b00_0000_0010,
    S_SKIP_RD  = 10'b00_0000_0100,
    S_SKIP_CMP = 10'b00_0000_1000,
    S_HEAD_RD  = 10'b00_0001_0000,
    S_HEAD_CMP = 10'b00_0010_0000,
    S_REL      = 10'b00_0100_0000,
    S_RETR     = 10'b00_1000_0000,
    S_FIRE     = 10'b01_0000_0000,
    S_OUT      = 10'b10_0000_0000
  } state_t;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_LAST) ? '0 : p + 1'b1;
  endfunction

  state_t           state_r, state_nxt;
  logic [CLK_W-1:0] clock_r, clock_nxt;
  logic [CLK_W-1:0] release_r, release_nxt;
  logic [PTR_W-1:0] head_r, head_nxt;
  logic [PTR_W-1:0] tail_r, tail_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             pending_r, pending_nxt;
  stick_t           stick_r, stick_nxt;

  logic [7:0]       node_mask_r;
  logic [15:0]      cooldown_r;
  logic             single_r;

  logic [2:0]       cmd_r, cmd_nxt;
  logic [7:0]       mask_r, mask_nxt;
  logic [CLK_W-1:0] val_r, val_nxt;
  logic             rvalid_r, rvalid_nxt;
  logic [CLK_W-1:0] rclock_r, rclock_nxt;
  logic [1:0]       drive_r, drive_nxt;
  logic             refused_r, refused_nxt;

  logic             out_valid_r, out_valid_nxt;
  logic [39:0]      out_data_r, out_data_nxt;
  logic             out_user_r, out_user_nxt;

  logic             ram_we, ram_re;
  logic [CLK_W-1:0] ram_rdata;
  alu_req_t         alu_req;
  alu_res_t         alu_res;

  logic             in_acc;
  logic             cfg_wr;
  logic             addressed;
  logic [CLK_W-1:0] cooldown_x;

  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign addressed  = ((mask_r & node_mask_r) != '0);
  assign cooldown_x = {16'b0, cooldown_r};

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  always_comb begin
    case (cfg_paddr[3:2])
      REG_NODE_MASK: cfg_prdata = {24'b0, node_mask_r};
      REG_COOLDOWN:  cfg_prdata = {16'b0, cooldown_r};
      REG_SINGLE:    cfg_prdata = {31'b0, single_r};
      default:       cfg_prdata = '0;
    endcase
  end

  tss_ram #(
    .WIDTH (CLK_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .we    (ram_we),
    .waddr (tail_r),
    .wdata (val_r),
    .re    (ram_re),
    .raddr (head_r),
    .rdata (ram_rdata)
  );

  tss_alu u_alu (
    .req (alu_req),
    .res (alu_res)
  );

  always_comb begin
    state_nxt     = state_r;
    clock_nxt     = clock_r;
    release_nxt   = release_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    count_nxt     = count_r;
    pending_nxt   = pending_r;
    stick_nxt     = stick_r;
    cmd_nxt       = cmd_r;
    mask_nxt      = mask_r;
    val_nxt       = val_r;
    rvalid_nxt    = rvalid_r;
    rclock_nxt    = rclock_r;
    drive_nxt     = drive_r;
    refused_nxt   = refused_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_user_nxt  = out_user_r;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    alu_req       = '{op: ALU_ADD, a: clock_r, b: cooldown_x};

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          cmd_nxt     = in_tuser;
          mask_nxt    = in_tdata[7:0];
          val_nxt     = in_tdata[39:8];
          rvalid_nxt  = 1'b0;
          rclock_nxt  = '0;
          drive_nxt   = DRIVE_NONE;
          refused_nxt = 1'b0;
          state_nxt   = S_MSG;
        end
      end
      S_MSG: begin
        state_nxt = S_HEAD_RD;
        case (cmd_r)
          CMD_TICK: begin
            alu_req   = '{op: ALU_ADD, a: clock_r, b: CLK_W'(1)};
            clock_nxt = alu_res.sum;
          end
          CMD_REQ: begin
            rvalid_nxt = 1'b1;
            rclock_nxt = clock_r;
          end
          CMD_SET: begin
            alu_req   = '{op: ALU_ADD, a: clock_r, b: val_r};
            clock_nxt = alu_res.sum;
            if (!alu_res.carry && (val_r != '0) && (count_r != '0)) begin
              state_nxt = S_SKIP_RD;
            end
          end
          CMD_SCHED: begin
            if (addressed && (count_r != CNT_FULL)) begin
              ram_we    = 1'b1;
              tail_nxt  = ptr_inc(tail_r);
              count_nxt = count_r + 1'b1;
            end
          end
          CMD_HIT: begin
            if (addressed) begin
              pending_nxt = 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
      S_SKIP_RD: begin
        ram_re    = 1'b1;
        state_nxt = S_SKIP_CMP;
      end
      S_SKIP_CMP: begin
        alu_req   = '{op: ALU_SUB, a: ram_rdata, b: clock_r};
        state_nxt = S_HEAD_RD;
        if (!alu_res.carry) begin
          pending_nxt = 1'b1;
          head_nxt    = ptr_inc(head_r);
          count_nxt   = count_r - 1'b1;
          if (count_r > CNT_ONE) begin
            state_nxt = S_SKIP_RD;
          end
        end
      end
      S_HEAD_RD: begin
        if (count_r != '0) begin
          ram_re    = 1'b1;
          state_nxt = S_HEAD_CMP;
        end else begin
          state_nxt = S_REL;
        end
      end
      S_HEAD_CMP: begin
        alu_req   = '{op: ALU_SUB, a: ram_rdata, b: clock_r};
        state_nxt = S_REL;
        if (alu_res.zero) begin
          pending_nxt = 1'b1;
          head_nxt    = ptr_inc(head_r);
          count_nxt   = count_r - 1'b1;
        end
      end
      S_REL: begin
        alu_req   = '{op: ALU_SUB, a: clock_r, b: release_r};
        state_nxt = S_FIRE;
        if (alu_res.zero) begin
          case (stick_r)
            STICK_STRUCK: begin
              if (single_r) begin
                drive_nxt = DRIVE_RETRACT;
                stick_nxt = STICK_RETRACTED;
                state_nxt = S_RETR;
              end else begin
                stick_nxt = STICK_READY;
              end
            end
            STICK_RETRACTED: stick_nxt = STICK_READY;
            default: begin
            end
          endcase
        end
      end
      S_RETR: begin
        release_nxt = alu_res.sum;
        state_nxt   = S_FIRE;
      end
      S_FIRE: begin
        state_nxt = S_OUT;
        if (pending_r) begin
          pending_nxt = 1'b0;
          if (stick_r == STICK_READY) begin
            drive_nxt   = DRIVE_STRIKE;
            stick_nxt   = STICK_STRUCK;
            release_nxt = alu_res.sum;
          end else begin
            refused_nxt = 1'b1;
          end
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {5'b0, refused_r, drive_r, rclock_r};
          out_user_nxt  = rvalid_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      clock_r     <= '0;
      release_r   <= '0;
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      pending_r   <= 1'b0;
      stick_r     <= STICK_READY;
      out_valid_r <= 1'b0;
      node_mask_r <= NODE_MASK_RST;
      cooldown_r  <= COOLDOWN_RST;
      single_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clock_r     <= clock_nxt;
      release_r   <= release_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      pending_r   <= pending_nxt;
      stick_r     <= stick_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr) begin
        case (cfg_paddr[3:2])
          REG_NODE_MASK: node_mask_r <= cfg_pwdata[7:0];
          REG_COOLDOWN:  cooldown_r  <= cfg_pwdata[15:0];
          REG_SINGLE:    single_r    <= cfg_pwdata[0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    mask_r     <= mask_nxt;
    val_r      <= val_nxt;
    rvalid_r   <= rvalid_nxt;
    rclock_r   <= rclock_nxt;
    drive_r    <= drive_nxt;
    refused_r  <= refused_nxt;
    out_data_r <= out_data_nxt;
    out_user_r <= out_user_nxt;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_FULL)
    else $error("queue count above depth");

  a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> (head_r == tail_r))
    else $error("empty queue with unequal pointers");

  a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !pending_r)
    else $error("strike left pending between words");

  a_reply_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser[0]) |-> (out_tdata[31:0] == '0))
    else $error("reply clock set without reply");

endmodule

>>> tb/strike_schedule_checker.sv
// ----------------------------------------------------------------------------
// strike_schedule_checker: scoreboard for the timed strike scheduler
// Follows register writes and input words, predicts the result word of each
// input word and compares every result word, field by field, in order.
// ----------------------------------------------------------------------------
module strike_schedule_checker import tss_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [39:0] in_tdata,   // target_mask[7:0], value[39:8]
  input  logic [2:0]  in_tuser,   // cmd[2:0]
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [39:0] out_tdata,  // reply_clock[31:0], drive[33:32], refused[34]
  input  logic [0:0]  out_tuser,  // reply_valid[0]
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  input  logic        cfg_pready,
  output int          errors,
  output int          pending,
  output int          strikes,
  output int          retracts,
  output int          refusals,
  output int          drops,
  output int          skips
);

  localparam int QDEPTH = 16;

  typedef struct packed {
    logic        reply_valid;
    logic [31:0] reply_clock;
    logic [1:0]  drive;
    logic        refused;
  } strike_word_t;

  logic [7:0]   node_mask;
  logic [15:0]  cooldown;
  logic         retract_mode;

  logic [31:0]  vclock;
  logic [31:0]  strike_times [QDEPTH];
  logic [3:0]   q_rd;
  logic [3:0]   q_wr;
  int           q_cnt;
  logic         strike_pend;
  stick_t       stick;
  logic [31:0]  release_at;

  strike_word_t due_results[$];

  task automatic predict_strike_outcome(input logic [2:0] cmd, input logic [7:0] mask,
                                        input logic [31:0] val, output strike_word_t res);
    logic [31:0] new_clock;
    logic        aimed;
    res   = '0;
    aimed = |(mask & node_mask);
    case (cmd)
      CMD_TICK: vclock = vclock + 32'd1;
      CMD_REQ: begin
        res.reply_valid = 1'b1;
        res.reply_clock = vclock;
      end
      CMD_SET: begin
        new_clock = vclock + val;
        // forward jump: drop every head entry already overtaken
        if (new_clock > vclock) begin
          while (q_cnt > 0 && strike_times[q_rd] < new_clock) begin
            strike_pend = 1'b1;
            q_rd        = q_rd + 4'd1;
            q_cnt--;
            skips++;
          end
        end
        vclock = new_clock;
      end
      CMD_SCHED: begin
        if (aimed) begin
          if (q_cnt < QDEPTH) begin
            strike_times[q_wr] = val;
            q_wr               = q_wr + 4'd1;
            q_cnt++;
          end else begin
            drops++;
          end
        end
      end
      CMD_HIT: if (aimed) strike_pend = 1'b1;
      default: ;
    endcase

    if (q_cnt > 0 && strike_times[q_rd] == vclock) begin
      strike_pend = 1'b1;
      q_rd        = q_rd + 4'd1;
      q_cnt--;
    end

    if (vclock == release_at) begin
      if (stick == STICK_STRUCK) begin
        if (retract_mode) begin
          res.drive  = DRIVE_RETRACT;
          stick      = STICK_RETRACTED;
          release_at = vclock + {16'd0, cooldown};
        end else begin
          stick = STICK_READY;
        end
      end else if (stick == STICK_RETRACTED) begin
        stick = STICK_READY;
      end
    end

    if (strike_pend) begin
      strike_pend = 1'b0;
      if (stick == STICK_READY) begin
        res.drive  = DRIVE_STRIKE;
        stick      = STICK_STRUCK;
        release_at = vclock + {16'd0, cooldown};
      end else begin
        res.refused = 1'b1;
      end
    end
  endtask

  always @(posedge clk) begin : watch
    strike_word_t res;
    strike_word_t exp;
    if (!rst_n) begin
      node_mask    = NODE_MASK_RST;
      cooldown     = COOLDOWN_RST;
      retract_mode = 1'b0;
      vclock       = '0;
      q_rd         = '0;
      q_wr         = '0;
      q_cnt        = 0;
      strike_pend  = 1'b0;
      stick        = STICK_READY;
      release_at   = '0;
      errors       = 0;
      strikes      = 0;
      retracts     = 0;
      refusals     = 0;
      drops        = 0;
      skips        = 0;
      due_results.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (cfg_paddr[3:2])
          REG_NODE_MASK: node_mask    = cfg_pwdata[7:0];
          REG_COOLDOWN:  cooldown     = cfg_pwdata[15:0];
          REG_SINGLE:    retract_mode = cfg_pwdata[0];
          default: ;
        endcase
      end

      if (in_tvalid && in_tready) begin
        predict_strike_outcome(in_tuser, in_tdata[7:0], in_tdata[39:8], res);
        if (res.drive == DRIVE_STRIKE) strikes++;
        if (res.drive == DRIVE_RETRACT) retracts++;
        if (res.refused) refusals++;
        due_results.push_back(res);
      end

      if (out_tvalid && out_tready) begin
        if (due_results.size() == 0) begin
          $error("result word with none outstanding: tdata %h tuser %b", out_tdata, out_tuser);
          errors++;
        end else begin
          exp = due_results.pop_front();
          if (out_tuser[0] !== exp.reply_valid) begin
            $error("reply_valid: expected %0d, actual %0d", exp.reply_valid, out_tuser[0]);
            errors++;
          end
          if (out_tdata[31:0] !== exp.reply_clock) begin
            $error("reply_clock: expected %0d, actual %0d", exp.reply_clock, out_tdata[31:0]);
            errors++;
          end
          if (out_tdata[33:32] !== exp.drive) begin
            $error("drive: expected %0d, actual %0d", exp.drive, out_tdata[33:32]);
            errors++;
          end
          if (out_tdata[34] !== exp.refused) begin
            $error("refused: expected %0d, actual %0d", exp.refused, out_tdata[34]);
            errors++;
          end
        end
      end
    end
    pending = due_results.size();
  end

endmodule

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench for the timed strike scheduler
// Drives directed and random command words through seven register settings
// with random idling on both streams and one long result back-pressure spell;
// the checker beside the block predicts and compares every result word.
// ----------------------------------------------------------------------------
module tb_top import tss_pkg::*;;

  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        in_tvalid   = 1'b0;
  logic [39:0] in_tdata    = '0;  // target_mask[7:0], value[39:8]
  logic [2:0]  in_tuser    = '0;  // cmd[2:0]
  logic        out_tready  = 1'b0;
  logic        cfg_psel    = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite  = 1'b0;
  logic [3:0]  cfg_paddr   = '0;
  logic [31:0] cfg_pwdata  = '0;

  logic        in_tready;
  logic        out_tvalid;
  logic [39:0] out_tdata;  // reply_clock[31:0], drive[33:32], refused[34]
  logic [0:0]  out_tuser;  // reply_valid[0]
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  int errors, pending, strikes, retracts, refusals, drops, skips;

  logic        in_fire    = 1'b0;
  int          words_out  = 0;
  int          words_sent = 0;
  int          cfg_errors = 0;
  logic [31:0] sclk       = '0;            // running clock as the stimulus sees it
  logic [7:0]  node_now   = NODE_MASK_RST;
  bit          tx_quiet   = 1'b0;

  timed_strike_scheduler u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  strike_schedule_checker u_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_pready  (cfg_pready),
    .errors      (errors),
    .pending     (pending),
    .strikes     (strikes),
    .retracts    (retracts),
    .refusals    (refusals),
    .drops       (drops),
    .skips       (skips)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("timed_strike_scheduler verification failed");
    $finish;
  end

  always @(posedge clk) begin
    in_fire <= in_tvalid && in_tready;
    if (out_tvalid && out_tready) words_out <= words_out + 1;
  end

  // result side: short and long stalls, calm stretches, one long hold-off
  initial begin : result_sink
    int  stall_left;
    int  calm_left;
    int  r;
    bit  held;
    stall_left = 0;
    calm_left  = 0;
    held       = 1'b0;
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (!held && words_out >= 300) begin
        held = 1'b1;
        out_tready <= 1'b0;
        repeat (499) @(negedge clk);
      end else if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else begin
        out_tready <= 1'b1;
        if (calm_left > 0) begin
          calm_left--;
        end else begin
          r = $urandom_range(0, 99);
          if (r < 5) calm_left = $urandom_range(50, 150);
          else if (r < 25) stall_left = $urandom_range(1, 3);
          else if (r < 27) stall_left = $urandom_range(10, 40);
        end
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 96) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [7:0] pick_mask(input bit aimed);
    logic [7:0] m;
    m = 8'($urandom);
    if (aimed) return m | node_now;
    return m & ~node_now;
  endfunction

  task automatic send_word(input logic [2:0] cmd, input logic [7:0] mask,
                           input logic [31:0] val);
    int gap;
    gap = tx_quiet ? 0 : pick_gap();
    repeat (gap) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {val, mask};
    in_tuser  <= cmd;
    do @(negedge clk); while (!in_fire);
    if (cmd == CMD_TICK) sclk = sclk + 32'd1;
    else if (cmd == CMD_SET) sclk = sclk + val;
    if (cmd <= CMD_HIT) words_sent++;
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [31:0] data);
    logic [31:0] keep;
    case (idx)
      REG_NODE_MASK: keep = 32'h0000_00FF;
      REG_COOLDOWN:  keep = 32'h0000_FFFF;
      default:       keep = 32'h0000_0001;
    endcase
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= data;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(negedge clk);
    if (cfg_prdata !== (data & keep)) begin
      $error("cfg_prdata: expected %h, actual %h", data & keep, cfg_prdata);
      cfg_errors++;
    end
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  task automatic set_config(input logic [7:0] node, input logic [15:0] cool, input logic single);
    settle();
    cfg_write(REG_NODE_MASK, {24'd0, node});
    cfg_write(REG_COOLDOWN, {16'd0, cool});
    cfg_write(REG_SINGLE, {31'd0, single});
    node_now = node;
  endtask

  task automatic run_random(input int n);
    int          target;
    int          kind;
    int          k;
    int          i;
    int          r;
    logic [31:0] adj;
    logic [31:0] base;
    target = words_sent + n;
    while (words_sent < target) begin
      tx_quiet = ($urandom_range(0, 5) == 0);
      kind     = $urandom_range(0, 99);
      if (kind < 40) begin
        // strikes timed a few ticks ahead, then let the clock reach them
        k = $urandom_range(1, 3);
        for (i = 0; i < k; i++)
          send_word(CMD_SCHED, pick_mask($urandom_range(0, 5) != 0),
                    sclk + $urandom_range(0, 6));
        k = $urandom_range(0, 10);
        for (i = 0; i < k; i++) begin
          if ($urandom_range(0, 5) == 0) send_word(CMD_REQ, 8'($urandom), $urandom);
          else send_word(CMD_TICK, 8'($urandom), $urandom);
        end
      end else if (kind < 50) begin
        send_word(CMD_HIT, pick_mask($urandom_range(0, 3) != 0), $urandom);
        k = $urandom_range(0, 3);
        for (i = 0; i < k; i++) send_word(CMD_TICK, 8'($urandom), $urandom);
      end else if (kind < 65) begin
        r = $urandom_range(0, 99);
        if (r < 45) adj = $urandom_range(1, 20);
        else if (r < 70) adj = 32'd0 - $urandom_range(1, 80);
        else if (r < 78) adj = '0;
        else if (r < 88) adj = $urandom;
        else adj = $urandom_range(100, 5000);
        send_word(CMD_SET, 8'($urandom), adj);
      end else if (kind < 70) begin
        // fill the queue to its depth or past it, sometimes jump past the lot
        k    = $urandom_range(16, 18);
        base = sclk + $urandom_range(20, 200);
        for (i = 0; i < k; i++) send_word(CMD_SCHED, pick_mask(1'b1), base + i);
        if ($urandom_range(0, 1) == 1) send_word(CMD_SET, 8'($urandom), 32'd300);
      end else if (kind < 85) begin
        k = $urandom_range(5, 30);
        for (i = 0; i < k; i++) send_word(CMD_TICK, 8'($urandom), $urandom);
      end else begin
        send_word(3'($urandom_range(0, 7)), 8'($urandom), $urandom);
      end
    end
  endtask

  initial begin : stimulus
    int spins;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: reset defaults, node mask 0x01, cooldown 64, double stick
    send_word(CMD_REQ,   8'h00, 32'd0);
    send_word(CMD_TICK,  8'h00, 32'd0);
    send_word(CMD_SCHED, 8'h01, 32'd3);
    send_word(CMD_SCHED, 8'hFE, 32'd2);          // not for this node
    send_word(CMD_TICK,  8'h00, 32'd0);
    send_word(CMD_TICK,  8'h00, 32'd0);          // head due: strike
    send_word(CMD_HIT,   8'hFF, 32'hFFFF_FFFF);  // stick busy: refused
    send_word(CMD_HIT,   8'h00, 32'd0);
    send_word(CMD_SET,   8'h00, 32'd64);         // lands on the release time
    send_word(CMD_SCHED, 8'h81, 32'hFFFF_FFFF);
    send_word(CMD_SCHED, 8'hFF, 32'd0);
    send_word(CMD_SCHED, 8'h01, 32'd70);
    send_word(CMD_SET,   8'hFF, 32'd0);
    send_word(CMD_SET,   8'h00, 32'hFFFF_FFFF);  // backward: no skip
    send_word(CMD_SET,   8'h00, 32'd10);         // late head blocks the skip
    send_word(CMD_REQ,   8'hFF, 32'hFFFF_FFFF);
    send_word(3'd5,      8'h5A, 32'hA5A5_A5A5);
    send_word(3'd6,      8'hA5, 32'h5A5A_5A5A);
    send_word(3'd7,      8'hFF, 32'hFFFF_FFFF);
    send_word(CMD_SET,   8'h00, 32'hFFFF_FFFF - sclk);  // clock to all ones
    send_word(CMD_TICK,  8'h00, 32'd0);          // wraps to zero
    send_word(CMD_SET,   8'h00, 32'd63);
    send_word(CMD_SET,   8'h00, 32'd10);         // skips the entry at 70
    send_word(CMD_REQ,   8'h00, 32'd0);

    run_random(150);
    set_config(8'hFF, 16'd1, 1'b0);
    run_random(220);
    set_config(8'h80, 16'd0, 1'b1);
    run_random(200);
    set_config(8'h24, 16'd5, 1'b1);
    run_random(250);
    set_config(8'h01, 16'd3, 1'b1);
    run_random(250);
    set_config(8'hFF, 16'd12, 1'b0);
    run_random(150);
    set_config(8'h00, 16'hFFFF, 1'b0);
    run_random(100);

    in_tvalid <= 1'b0;
    for (spins = 0; pending != 0 && spins < 20000; spins++) @(negedge clk);
    repeat (60) @(negedge clk);

    $display("%0d command words over seven register settings, both stick modes",
             words_sent);
    $display("%0d strikes, %0d retracts, %0d refusals, %0d full-queue drops, %0d skipped",
             strikes, retracts, refusals, drops, skips);
    if (errors == 0 && cfg_errors == 0 && pending == 0) begin
      $display("timed_strike_scheduler verification clean");
    end else begin
      $display("timed_strike_scheduler verification failed");
    end
    $finish;
  end

endmodule
